FILE: hw/rtl/coifa_pkg.sv
// ---------------------------------------------------------------------------
// coifa_pkg
// Shared types, codes and helpers for the CANopen IMU frame assembler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package coifa_pkg;

  localparam int IdentW   = 11;
  localparam int LenW     = 4;
  localparam int DataW    = 64;
  localparam int NodeW    = 7;
  localparam int CountW   = 16;
  localparam int NumGroup = 4;
  localparam int GrpW     = 2;
  localparam int HbW      = 8;
  localparam int InTdataW = 80;
  localparam int InTuserW = 3;
  localparam int OutTdataW = 80;
  localparam int OutTuserW = 3;

  localparam logic [IdentW-1:0] HeartbeatBase = 11'h700;
  localparam logic [IdentW-1:0] Pdo1Base      = 11'h180;
  localparam logic [IdentW-1:0] Pdo2Base      = 11'h280;
  localparam logic [IdentW-1:0] Pdo3Base      = 11'h380;
  localparam logic [IdentW-1:0] Pdo4Base      = 11'h480;
  localparam logic [LenW-1:0]   FullLen       = 4'd8;
  localparam logic [NumGroup-1:0] AllGroups   = 4'hf;
  localparam logic [CountW-1:0] MostNeg       = 16'h8000;
  localparam logic [CountW-1:0] MostPos       = 16'h7fff;

  typedef enum logic [2:0] {
    KIND_IGNORED   = 3'd0,
    KIND_HEARTBEAT = 3'd1,
    KIND_MALFORMED = 3'd2,
    KIND_STORED    = 3'd3,
    KIND_GROUP     = 3'd4
  } kind_t;

  typedef enum logic {
    CFG_NODE = 1'b0,
    CFG_FLIP = 1'b1
  } cfg_idx_t;

  // outcome of one frame
  typedef struct packed {
    kind_t           kind;
    logic [HbW-1:0]  hb_state;
    logic [GrpW-1:0] grp;
    logic            store_en;
    logic            complete;
  } dec_t;

  function automatic logic [CountW-1:0] negate_sat(input logic [CountW-1:0] raw);
    logic [CountW-1:0] neg;
    neg = CountW'(~raw + 1'b1);
    return (raw == MostNeg) ? MostPos : neg;
  endfunction

  // four counts of one group, value a in the low bits; acceleration is
  // group 0 (a, b, c), quaternion xyz is group 3 (b, c, d)
  function automatic logic [DataW-1:0] format_group(input logic [DataW-1:0] word,
                                                    input logic [GrpW-1:0]  grp,
                                                    input logic             flip);
    logic [DataW-1:0] res;
    res = word;
    if (flip && grp == 2'd0) begin
      res[15:0]  = negate_sat(word[15:0]);
      res[31:16] = negate_sat(word[31:16]);
      res[47:32] = negate_sat(word[47:32]);
    end else if (flip && grp == 2'd3) begin
      res[31:16] = negate_sat(word[31:16]);
      res[47:32] = negate_sat(word[47:32]);
      res[63:48] = negate_sat(word[63:48]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/canopen_imu_frame_assembler.sv
// ---------------------------------------------------------------------------
// canopen_imu_frame_assembler
// Decodes CANopen heartbeat and four-PDO IMU frames into result records.
// ---------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                        tuser / tlast
// s_*      in   frame_ident, length_code, payload, zeros  extended, remote, error
// m_*      out  node_state, group_index, value_a..d       kind / last
// cfg_*    in   cfg_index selects node_number or flip_axes, cfg_data
//
// One cycle per frame, m_tready high, via the input and result registers.
// A frame completing a sample gives four beats, one per cycle while m_tready
// is high, and the next frame waits in the input register meanwhile.
// Reset clears received mask, valid flags and flip_axes, sets node_number 1.
// m_tready low holds the result and, once the input register fills, s_tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module canopen_imu_frame_assembler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // frame_ident[10:0], length_code[14:11], payload[78:15]
  input  wire logic [coifa_pkg::InTdataW-1:0]    s_tdata,
  // extended_flag[0], remote_flag[1], error_flag[2]
  input  wire logic [coifa_pkg::InTuserW-1:0]    s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // node_state[7:0], group_index[9:8], value_a[25:10], value_b[41:26],
  // value_c[57:42], value_d[73:58]
  output logic [coifa_pkg::OutTdataW-1:0]        m_tdata,
  // kind[2:0]
  output logic [coifa_pkg::OutTuserW-1:0]        m_tuser,
  output logic                                   m_tlast,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [coifa_pkg::NodeW-1:0]       cfg_data
);

  logic                           in_valid;
  logic [coifa_pkg::IdentW-1:0]   in_ident;
  logic [coifa_pkg::LenW-1:0]     in_len;
  logic [coifa_pkg::DataW-1:0]    in_payload;
  logic [coifa_pkg::InTuserW-1:0] in_flags;
  logic [coifa_pkg::NodeW-1:0]    node_number;
  logic                           flip_axes;
  logic                           take;
  logic [coifa_pkg::NumGroup-1:0] mask;
  coifa_pkg::dec_t                dec;
  coifa_pkg::kind_t               out_kind;
  logic [coifa_pkg::HbW-1:0]      out_hb;
  logic [coifa_pkg::GrpW-1:0]     out_grp;
  logic [coifa_pkg::DataW-1:0]    out_vals;

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ident   <= s_tdata[10:0];
      in_len     <= s_tdata[14:11];
      in_payload <= s_tdata[78:15];
      in_flags   <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_number <= coifa_pkg::NodeW'(1);
      flip_axes   <= 1'b0;
    end else if (cfg_we) begin
      unique case (coifa_pkg::cfg_idx_t'(cfg_index))
        coifa_pkg::CFG_NODE: node_number <= cfg_data;
        coifa_pkg::CFG_FLIP: flip_axes   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  coifa_decode u_decode (
    .ident    (in_ident),
    .ext_flag (in_flags[0]),
    .rtr_flag (in_flags[1]),
    .err_flag (in_flags[2]),
    .len      (in_len),
    .payload  (in_payload),
    .node     (node_number),
    .mask     (mask),
    .dec      (dec)
  );

  coifa_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .dec       (dec),
    .payload   (in_payload),
    .flip      (flip_axes),
    .take      (take),
    .mask      (mask),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_hb    (out_hb),
    .out_grp   (out_grp),
    .out_vals  (out_vals),
    .out_last  (m_tlast)
  );

  assign m_tdata = {6'b0, out_vals, out_grp, out_hb};
  assign m_tuser = out_kind;

endmodule

`default_nettype wire

FILE: hw/rtl/coifa_decode.sv
// ---------------------------------------------------------------------------
// coifa_decode
// Classifies a registered CAN frame against this node's objects.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coifa_decode (
  input  wire logic [coifa_pkg::IdentW-1:0]   ident,
  input  wire logic                           ext_flag,
  input  wire logic                           rtr_flag,
  input  wire logic                           err_flag,
  input  wire logic [coifa_pkg::LenW-1:0]     len,
  input  wire logic [coifa_pkg::DataW-1:0]    payload,
  input  wire logic [coifa_pkg::NodeW-1:0]    node,
  input  wire logic [coifa_pkg::NumGroup-1:0] mask,
  output coifa_pkg::dec_t                     dec
);

  logic [coifa_pkg::IdentW-1:0]   node_ext;
  logic                           pad_bad;
  logic [coifa_pkg::NumGroup-1:0] mask_new;
  logic                           is_pdo;
  logic [coifa_pkg::GrpW-1:0]     grp;

  assign node_ext = {{(coifa_pkg::IdentW - coifa_pkg::NodeW){1'b0}}, node};

  // any nonzero byte inside the declared length, past the state byte
  always_comb begin
    pad_bad = 1'b0;
    for (int i = 1; i < 8; i++) begin
      if (coifa_pkg::LenW'(i) < len && payload[8*i +: 8] != 8'h00) pad_bad = 1'b1;
    end
  end

  always_comb begin
    is_pdo = 1'b1;
    grp    = 2'd0;
    if (ident == coifa_pkg::Pdo1Base + node_ext) begin
      grp = 2'd0;
    end else if (ident == coifa_pkg::Pdo2Base + node_ext) begin
      grp = 2'd1;
    end else if (ident == coifa_pkg::Pdo3Base + node_ext) begin
      grp = 2'd2;
    end else if (ident == coifa_pkg::Pdo4Base + node_ext) begin
      grp = 2'd3;
    end else begin
      is_pdo = 1'b0;
    end
  end

  assign mask_new = mask | (coifa_pkg::NumGroup'(1) << grp);

  always_comb begin
    dec = '{kind: coifa_pkg::KIND_IGNORED, hb_state: '0, grp: '0,
            store_en: 1'b0, complete: 1'b0};
    if (ext_flag || rtr_flag || err_flag) begin
      dec.kind = coifa_pkg::KIND_IGNORED;
    end else if (ident == coifa_pkg::HeartbeatBase + node_ext) begin
      if (len == '0 || len > coifa_pkg::FullLen || pad_bad) begin
        dec.kind = coifa_pkg::KIND_MALFORMED;
      end else begin
        dec.kind     = coifa_pkg::KIND_HEARTBEAT;
        dec.hb_state = payload[7:0];
      end
    end else if (is_pdo) begin
      if (len != coifa_pkg::FullLen) begin
        dec.kind = coifa_pkg::KIND_MALFORMED;
      end else begin
        dec.store_en = 1'b1;
        dec.grp      = grp;
        dec.complete = (mask_new == coifa_pkg::AllGroups);
        dec.kind     = dec.complete ? coifa_pkg::KIND_GROUP : coifa_pkg::KIND_STORED;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/coifa_emit.sv
// ---------------------------------------------------------------------------
// coifa_emit
// Group store, received mask and result register with sample-group burst.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coifa_emit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire coifa_pkg::dec_t                 dec,
  input  wire logic [coifa_pkg::DataW-1:0]     payload,
  input  wire logic                            flip,
  output logic                                 take,
  output logic [coifa_pkg::NumGroup-1:0]       mask,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output coifa_pkg::kind_t                     out_kind,
  output logic [coifa_pkg::HbW-1:0]            out_hb,
  output logic [coifa_pkg::GrpW-1:0]           out_grp,
  output logic [coifa_pkg::DataW-1:0]          out_vals,
  output logic                                 out_last
);

  logic [coifa_pkg::DataW-1:0] store [coifa_pkg::NumGroup];
  logic [coifa_pkg::GrpW-1:0]  beat_next;
  logic [coifa_pkg::DataW-1:0] first_word;

  // result register frees up this cycle: empty, or its final beat leaves
  assign take = in_valid && (!out_valid || (out_ready && out_last));

  assign beat_next  = out_grp + 2'd1;
  // group 0 may be the frame being stored right now
  assign first_word = (dec.grp == 2'd0) ? payload : store[0];

  always_ff @(posedge clk) begin
    if (take && dec.store_en) begin
      store[dec.grp] <= payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take && dec.store_en) begin
        mask <= dec.complete ? '0 : (mask | (coifa_pkg::NumGroup'(1) << dec.grp));
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready && out_last) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_kind <= dec.kind;
      out_hb   <= dec.hb_state;
      if (dec.complete) begin
        out_grp  <= 2'd0;
        out_vals <= coifa_pkg::format_group(first_word, 2'd0, flip);
        out_last <= 1'b0;
      end else begin
        out_grp  <= dec.grp;
        out_vals <= '0;
        out_last <= 1'b1;
      end
    end else if (out_valid && out_ready && !out_last) begin
      // next beat of a sample; the store is frozen until the burst ends
      out_grp  <= beat_next;
      out_vals <= coifa_pkg::format_group(store[beat_next], beat_next, flip);
      out_last <= (beat_next == 2'd3);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/coifa_checker.sv
// ---------------------------------------------------------------------------
// coifa_checker
// Port-level checks on the assembler's result stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coifa_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [coifa_pkg::OutTdataW-1:0]    m_tdata,
  input wire logic [coifa_pkg::OutTuserW-1:0]    m_tuser,
  input wire logic                               m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed under stall");

  // only a sample burst spans several results
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != coifa_pkg::KIND_GROUP |-> m_tlast)
    else $error("non-group result without last");

  // burst ends on group 3
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == coifa_pkg::KIND_GROUP && m_tlast |-> m_tdata[9:8] == 2'd3)
    else $error("burst ended early");

  // burst beats follow directly, groups counting up
  a_next: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser == coifa_pkg::KIND_GROUP && !m_tlast
    |=> m_tvalid && m_tuser == coifa_pkg::KIND_GROUP
        && m_tdata[9:8] == $past(m_tdata[9:8]) + 2'd1)
    else $error("burst broken");

  // first cycle out of reset is empty
  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !m_tvalid)
    else $error("result after reset");

endmodule

bind canopen_imu_frame_assembler coifa_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/canopen_imu_frame_assembler_tb.sv
// ---------------------------------------------------------------------------
// canopen_imu_frame_assembler_tb
// Self-checking bench: CAN frame requests go in on the s_* stream, and every
// result beat is checked against a behavioural decoder kept in the bench.
// Directed frames cover flags, heartbeat length and padding rules, PDO length,
// group overwrite, axis flip saturation and node zero. Random traffic then
// runs under several node/flip settings with gaps and stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module canopen_imu_frame_assembler_tb;
  import coifa_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 300;

  typedef struct {
    logic [IdentW-1:0] ident;
    logic              ext;
    logic              rtr;
    logic              err;
    logic [LenW-1:0]   len;
    logic [DataW-1:0]  data;
  } can_frame_t;

  typedef struct {
    kind_t                   kind;
    logic [HbW-1:0]          hb_state;
    logic [GrpW-1:0]         grp;
    logic [3:0][CountW-1:0]  counts;
    logic                    last;
  } frame_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [InTdataW-1:0]    s_tdata = '0;
  logic [InTuserW-1:0]    s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OutTdataW-1:0]   m_tdata;
  logic [OutTuserW-1:0]   m_tuser;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [NodeW-1:0]       cfg_data = '0;

  // decoder state mirrored in the bench
  logic [DataW-1:0]       group_words [NumGroup];
  logic [NumGroup-1:0]    groups_seen;
  logic [NodeW-1:0]       node_cfg;
  logic                   flip_cfg;

  frame_result_t          expected_results [$];

  int  frames_sent;
  int  useful_frames;
  int  samples_completed;
  int  results_checked;
  int  mismatches;
  int  cycle_count;
  bit  tx_steady;
  bit  rx_steady;
  bit  stall_now;

  canopen_imu_frame_assembler u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int g = 0; g < NumGroup; g++) group_words[g] = '0;
    groups_seen = '0;
    node_cfg    = 7'd1;
    flip_cfg    = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 7) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [CountW-1:0] flip_count(input logic [CountW-1:0] c);
    if (c == MostNeg) return MostPos;
    return -c;
  endfunction

  function automatic void push_result(input kind_t kind, input logic [HbW-1:0] hb,
                                      input logic [GrpW-1:0] grp,
                                      input logic [DataW-1:0] counts,
                                      input logic last);
    frame_result_t r;
    r.kind     = kind;
    r.hb_state = hb;
    r.grp      = grp;
    r.counts   = counts;
    r.last     = last;
    expected_results.push_back(r);
  endfunction

  // works out the result beats one accepted frame causes
  function automatic void decode_frame(input can_frame_t f);
    logic              bad;
    logic [GrpW-1:0]   grp;
    logic [3:0][CountW-1:0] c;
    if (f.ext || f.rtr || f.err) begin
      push_result(KIND_IGNORED, '0, '0, '0, 1'b1);
      return;
    end
    if (f.ident == IdentW'(HeartbeatBase + node_cfg)) begin
      bad = (f.len == 0) || (f.len > FullLen);
      for (int i = 1; i < 8; i++) begin
        if (i < f.len && f.data[8*i +: 8] != 8'h00) bad = 1'b1;
      end
      if (bad) push_result(KIND_MALFORMED, '0, '0, '0, 1'b1);
      else push_result(KIND_HEARTBEAT, f.data[7:0], '0, '0, 1'b1);
      useful_frames++;
      return;
    end
    if (f.ident == IdentW'(Pdo1Base + node_cfg)) grp = 2'd0;
    else if (f.ident == IdentW'(Pdo2Base + node_cfg)) grp = 2'd1;
    else if (f.ident == IdentW'(Pdo3Base + node_cfg)) grp = 2'd2;
    else if (f.ident == IdentW'(Pdo4Base + node_cfg)) grp = 2'd3;
    else begin
      push_result(KIND_IGNORED, '0, '0, '0, 1'b1);
      return;
    end
    useful_frames++;
    if (f.len != FullLen) begin
      push_result(KIND_MALFORMED, '0, '0, '0, 1'b1);
      return;
    end
    group_words[grp] = f.data;
    groups_seen[grp] = 1'b1;
    if (groups_seen != AllGroups) begin
      push_result(KIND_STORED, '0, grp, '0, 1'b1);
      return;
    end
    groups_seen = '0;
    samples_completed++;
    for (int g = 0; g < NumGroup; g++) begin
      c = group_words[g];
      if (flip_cfg && g == 0) begin
        for (int k = 0; k < 3; k++) c[k] = flip_count(c[k]);
      end else if (flip_cfg && g == 3) begin
        for (int k = 1; k < 4; k++) c[k] = flip_count(c[k]);
      end
      push_result(KIND_GROUP, '0, GrpW'(g), c, g == 3);
    end
  endfunction

  // ---- frame builders ----

  function automatic can_frame_t make_pdo(input int g, input logic [DataW-1:0] data,
                                          input logic [LenW-1:0] len);
    can_frame_t f;
    case (g)
      0:       f.ident = Pdo1Base + node_cfg;
      1:       f.ident = Pdo2Base + node_cfg;
      2:       f.ident = Pdo3Base + node_cfg;
      default: f.ident = Pdo4Base + node_cfg;
    endcase
    f.ext  = 1'b0;
    f.rtr  = 1'b0;
    f.err  = 1'b0;
    f.len  = len;
    f.data = data;
    return f;
  endfunction

  // bytes past the length code stay random; clean zeroes the padding
  function automatic can_frame_t make_heartbeat(input logic [HbW-1:0] state,
                                                input logic [LenW-1:0] len,
                                                input logic clean);
    can_frame_t f;
    f.ident     = HeartbeatBase + node_cfg;
    f.ext       = 1'b0;
    f.rtr       = 1'b0;
    f.err       = 1'b0;
    f.len       = len;
    f.data      = {$urandom, $urandom};
    f.data[7:0] = state;
    for (int i = 1; i < 8; i++) begin
      if (clean && i < len) f.data[8*i +: 8] = 8'h00;
    end
    return f;
  endfunction

  function automatic logic [DataW-1:0] rand_counts();
    logic [3:0][CountW-1:0] c;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 9))
        0:       c[k] = MostNeg;
        1:       c[k] = MostPos;
        2:       c[k] = 16'h0000;
        3:       c[k] = 16'hffff;
        default: c[k] = CountW'($urandom);
      endcase
    end
    return c;
  endfunction

  function automatic logic [LenW-1:0] bad_pdo_len();
    logic [LenW-1:0] len;
    len = LenW'($urandom_range(0, 14));
    if (len >= FullLen) len++;
    return len;
  endfunction

  // ---- stimulus plumbing ----

  task automatic send_frame(input can_frame_t f);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, f.data, f.len, f.ident};
    s_tuser  <= {f.err, f.rtr, f.ext};
    do @(posedge clk); while (!s_tready);
    decode_frame(f);
    frames_sent++;
    if (!tx_steady && $urandom_range(0, 1) == 0) begin
      s_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // every frame gives a result, so an empty queue means the block is idle
  task automatic set_config(input logic [NodeW-1:0] node, input logic flip);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NODE;
    cfg_data  <= node;
    @(posedge clk);
    cfg_index <= CFG_FLIP;
    cfg_data  <= NodeW'(flip);
    @(posedge clk);
    cfg_we   <= 1'b0;
    node_cfg = node;
    flip_cfg = flip;
  endtask

  task automatic send_noise_frame();
    can_frame_t f;
    case ($urandom_range(0, 2))
      0: begin
        f = make_heartbeat(HbW'($urandom), LenW'($urandom_range(0, 15)),
                           $urandom_range(0, 3) != 0);
      end
      1: begin
        f.ident = IdentW'($urandom);
        f.ext   = 1'($urandom_range(0, 1));
        f.rtr   = 1'($urandom_range(0, 1));
        f.err   = 1'($urandom_range(0, 1));
        f.len   = LenW'($urandom);
        f.data  = {$urandom, $urandom};
      end
      default: begin
        // one of our PDO identifiers with a frame flag raised
        f     = make_pdo($urandom_range(0, 3), rand_counts(), FullLen);
        f.ext = 1'($urandom_range(0, 1));
        f.rtr = 1'($urandom_range(0, 1));
        f.err = !(f.ext || f.rtr) || ($urandom_range(0, 1) != 0);
      end
    endcase
    send_frame(f);
  endtask

  task automatic send_random_sample();
    int order [4];
    int j;
    int t;
    order = '{0, 1, 2, 3};
    for (int i = 3; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 7) == 0) send_noise_frame();
      if ($urandom_range(0, 9) == 0) send_frame(make_pdo(order[i], rand_counts(), bad_pdo_len()));
      if (i < 3 && $urandom_range(0, 9) == 0) begin
        send_frame(make_pdo(order[i], rand_counts(), FullLen));
      end
      send_frame(make_pdo(order[i], rand_counts(), FullLen));
    end
  endtask

  // ---- tests ----

  task automatic test_directed_frames();
    can_frame_t f;
    set_config(7'd1, 1'b0);
    f = make_pdo(0, 64'h1111_2222_3333_4444, FullLen);
    f.ext = 1'b1;
    send_frame(f);
    f.ext = 1'b0;
    f.rtr = 1'b1;
    send_frame(f);
    f.rtr = 1'b0;
    f.err = 1'b1;
    send_frame(f);
    f = make_pdo(0, '1, 4'hf);
    f.ident = '1;
    send_frame(f);
    f.ident = '0;
    f.len   = '0;
    f.data  = '0;
    send_frame(f);
    // heartbeats: bytes beyond the length code do not matter
    send_frame(make_heartbeat(8'h05, 4'd1, 1'b0));
    send_frame(make_heartbeat(8'hff, 4'd8, 1'b1));
    send_frame(make_heartbeat(8'h00, 4'd3, 1'b1));
    send_frame(make_heartbeat(8'h7f, 4'd0, 1'b1));
    send_frame(make_heartbeat(8'h7f, 4'd9, 1'b1));
    send_frame(make_heartbeat(8'h7f, 4'd15, 1'b1));
    f = make_heartbeat(8'h05, 4'd4, 1'b1);
    f.data[31:24] = 8'h01;
    send_frame(f);
    // short and overlong PDOs are neither stored nor marked
    send_frame(make_pdo(0, rand_counts(), 4'd7));
    send_frame(make_pdo(2, rand_counts(), 4'd0));
    send_frame(make_pdo(3, rand_counts(), 4'd15));
    send_frame(make_pdo(0, 64'hffff_0000_7fff_8000, FullLen));
    send_frame(make_pdo(1, rand_counts(), FullLen));
    send_frame(make_pdo(1, 64'h0123_4567_89ab_cdef, FullLen));
    send_frame(make_pdo(2, rand_counts(), FullLen));
    send_frame(make_pdo(3, '1, FullLen));
  endtask

  task automatic test_flip_and_node_zero();
    set_config(7'd127, 1'b1);
    send_frame(make_heartbeat(8'h80, 4'd2, 1'b1));
    send_frame(make_pdo(3, {4{MostNeg}}, FullLen));
    send_frame(make_pdo(2, rand_counts(), FullLen));
    send_frame(make_pdo(1, rand_counts(), FullLen));
    send_frame(make_pdo(0, {4{MostNeg}}, FullLen));
    set_config(7'd0, 1'b1);
    send_frame(make_heartbeat(8'h04, 4'd1, 1'b1));
    send_frame(make_pdo(0, 64'h8001_0001_ffff_7fff, FullLen));
    send_frame(make_pdo(1, rand_counts(), FullLen));
    send_frame(make_pdo(2, rand_counts(), FullLen));
    send_frame(make_pdo(3, 64'h7fff_8000_0001_ffff, FullLen));
  endtask

  task automatic test_random_traffic();
    int target;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       set_config(7'd1, 1'b0);
        1:       set_config(7'd127, 1'b1);
        2:       set_config(7'd0, 1'b0);
        default: set_config(NodeW'($urandom_range(1, 126)), p[0]);
      endcase
      target = useful_frames + 40;
      while (useful_frames < target) begin
        if ($urandom_range(0, 9) < 7) send_random_sample();
        else send_noise_frame();
      end
    end
  endtask

  // back-to-back requests with the receiver always ready
  task automatic test_streaming();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (4) send_random_sample();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain_results();
  endtask

  // receiver holds off long enough for the block to back up into s_tready
  task automatic test_output_hold_off();
    set_config(NodeW'($urandom_range(1, 126)), 1'b1);
    tx_steady = 1'b1;
    stall_now = 1'b1;
    repeat (3) send_random_sample();
    tx_steady = 1'b0;
    drain_results();
  endtask

  // ---- receiver ----

  initial begin : result_ready
    forever begin
      @(posedge clk);
      if (stall_now) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        stall_now = 1'b0;
        m_tready <= 1'b1;
      end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR beat %0d: %s got 0x%0h expected 0x%0h", results_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, kind", 64'(m_tuser), '0);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser != want.kind) report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
        if (m_tdata[7:0] != want.hb_state) report_mismatch("node state", 64'(m_tdata[7:0]),
                                                           64'(want.hb_state));
        if (m_tdata[9:8] != want.grp) report_mismatch("group_index", 64'(m_tdata[9:8]),
                                                      64'(want.grp));
        if (m_tdata[25:10] != want.counts[0]) report_mismatch("value_a", 64'(m_tdata[25:10]),
                                                              64'(want.counts[0]));
        if (m_tdata[41:26] != want.counts[1]) report_mismatch("value_b", 64'(m_tdata[41:26]),
                                                              64'(want.counts[1]));
        if (m_tdata[57:42] != want.counts[2]) report_mismatch("value_c", 64'(m_tdata[57:42]),
                                                              64'(want.counts[2]));
        if (m_tdata[73:58] != want.counts[3]) report_mismatch("value_d", 64'(m_tdata[73:58]),
                                                              64'(want.counts[3]));
        if (m_tlast != want.last) report_mismatch("last", 64'(m_tlast), 64'(want.last));
      end
      results_checked++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles, %0d beats still awaited", cycle_count,
             expected_results.size());
    $display("canopen_imu_frame_assembler verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_flip_and_node_zero();
    test_random_traffic();
    test_streaming();
    test_output_hold_off();
    drain_results();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("ERROR %0d beats never arrived", expected_results.size());
      mismatches++;
    end
    $display("Sent %0d frames (%0d addressed to the node), %0d samples assembled, %0d beats checked",
             frames_sent, useful_frames, samples_completed, results_checked);
    $display("Nodes 0, 1, 127 and random; axis flip on and off; gaps, stalls and a long hold-off");
    if (mismatches == 0) begin
      $display("canopen_imu_frame_assembler verification clean");
    end else begin
      $display("canopen_imu_frame_assembler verification failed");
    end
    $finish;
  end

endmodule
